FILE: sv/rccsg_pkg.sv
// Shared types and constants of the raycast column span generator.
package rccsg_pkg;

  // Default values of the top-level parameters.
  localparam int unsigned SCREEN_ROWS_DEF      = 512;
  localparam int unsigned MAX_TEXTURE_SIZE_DEF = 256;

  // Field widths.
  localparam int unsigned COL_W    = 10;
  localparam int unsigned ROW_W    = 9;
  localparam int unsigned DIST_W   = 16;
  localparam int unsigned FRAC_W   = 12;
  localparam int unsigned TEXID_W  = 2;
  localparam int unsigned TEXSZ_W  = 9;
  localparam int unsigned TEXEL_W  = 8;
  localparam int unsigned COLOR_W  = 32;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned HEIGHT_W = 13;

  // Stream and register port widths.
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 72;
  localparam int unsigned ADDR_W      = 4;
  localparam int unsigned APB_DATA_W  = 32;

  // Serial divider widths: the dividend covers SCREEN_ROWS * 256 up to 2^19.
  localparam int unsigned DIV_W = 20;
  localparam int unsigned DVS_W = 16;

  localparam logic [DVS_W-1:0]    MIN_DIST   = DVS_W'(26);
  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = HEIGHT_W'(8191);

  // Pixel kinds.
  localparam logic [KIND_W-1:0] KIND_CEIL  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WALL  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FLOOR = 2'd2;

  // Register indexes.
  localparam logic [1:0] REG_CEIL_COLOR  = 2'd0;
  localparam logic [1:0] REG_FLOOR_COLOR = 2'd1;
  localparam logic [1:0] REG_TEX_WIDTH   = 2'd2;
  localparam logic [1:0] REG_TEX_HEIGHT  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div_start;
    logic commit;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mode;
    logic is_wall;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

FILE: sv/rccsg_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module rccsg_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [rccsg_pkg::DIV_W-1:0]     dividend_i,
  input  logic [rccsg_pkg::DVS_W-1:0]     divisor_i,
  output logic                            busy_o,
  output logic                            done_o,
  output logic [rccsg_pkg::DIV_W-1:0]     quot_o
);

  localparam int unsigned CNT_W = $clog2(rccsg_pkg::DIV_W);

  logic [rccsg_pkg::DIV_W-1:0] dvd_q;
  logic [rccsg_pkg::DVS_W-1:0] dvs_q;
  logic [rccsg_pkg::DVS_W-1:0] rem_q;
  logic [CNT_W-1:0]            cnt_q;
  logic                        busy_q;
  logic                        done_q;

  logic [rccsg_pkg::DVS_W:0]   trial;
  logic [rccsg_pkg::DVS_W:0]   trial_sub;
  logic                        ge;

  assign trial     = {rem_q, dvd_q[rccsg_pkg::DIV_W-1]};
  assign ge        = (trial >= {1'b0, dvs_q});
  assign trial_sub = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(rccsg_pkg::DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // The quotient bits shift into the dividend register as it empties.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[rccsg_pkg::DIV_W-2:0], ge};
      rem_q <= ge ? trial_sub[rccsg_pkg::DVS_W-1:0] : trial[rccsg_pkg::DVS_W-1:0];
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

FILE: sv/rccsg_ctrl.sv
// Controller state machine that sequences setup and row beats.
module rccsg_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rccsg_pkg::sts_t  sts_i,
  output rccsg_pkg::cmd_t  cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DECODE = 2'd1;
  localparam logic [1:0] ST_DIV    = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        // Setups and wall rows need a division; sky and floor rows do not.
        if (!sts_i.mode || sts_i.is_wall) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          if (!sts_i.mode) begin
            cmd_o.commit = 1'b1;
            state_d      = ST_IDLE;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide state");

  a_start_leads_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> state_q == ST_DIV && !sts_i.div_done)
    else $error("divide state not entered after a divider start");

endmodule

FILE: sv/rccsg_dp.sv
// Datapath: registers, item latch, span arithmetic, divider and output register.
module rccsg_dp #(
  parameter int unsigned SCREEN_ROWS      = rccsg_pkg::SCREEN_ROWS_DEF,
  parameter int unsigned MAX_TEXTURE_SIZE = rccsg_pkg::MAX_TEXTURE_SIZE_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  rccsg_pkg::cmd_t                       cmd_i,
  output rccsg_pkg::sts_t                       sts_o,
  input  logic [rccsg_pkg::IN_TDATA_W-1:0]      s_tdata_i,
  input  logic                                  s_tuser_i,
  output logic                                  m_tvalid_o,
  input  logic                                  m_tready_i,
  output logic [rccsg_pkg::OUT_TDATA_W-1:0]     m_tdata_o,
  output logic [rccsg_pkg::KIND_W-1:0]          m_tuser_o,
  input  logic                                  psel_i,
  input  logic                                  penable_i,
  input  logic                                  pwrite_i,
  input  logic [rccsg_pkg::ADDR_W-1:0]          paddr_i,
  input  logic [rccsg_pkg::APB_DATA_W-1:0]      pwdata_i,
  output logic [rccsg_pkg::APB_DATA_W-1:0]      prdata_o
);

  localparam int unsigned SPAN_W = $clog2(SCREEN_ROWS);
  localparam int unsigned CMP_W  = (SPAN_W > rccsg_pkg::ROW_W) ? SPAN_W : rccsg_pkg::ROW_W;
  localparam int unsigned SUM_W  = rccsg_pkg::HEIGHT_W + 1;
  localparam int unsigned TXP_W  = rccsg_pkg::FRAC_W + rccsg_pkg::TEXSZ_W;
  localparam int unsigned TYP_W  = rccsg_pkg::ROW_W + rccsg_pkg::TEXSZ_W;
  localparam logic [SUM_W-1:0] HALF_V   = SUM_W'(SCREEN_ROWS / 2);
  localparam logic [SUM_W-1:0] LAST_ROW = SUM_W'(SCREEN_ROWS - 1);
  localparam logic [rccsg_pkg::DIV_W-1:0] SETUP_NUM = rccsg_pkg::DIV_W'(SCREEN_ROWS * 256);

  // Texture sizes of zero read as one, sizes above the maximum are clipped.
  function automatic logic [rccsg_pkg::TEXSZ_W-1:0] eff_size(
    input logic [rccsg_pkg::TEXSZ_W-1:0] s
  );
    logic [rccsg_pkg::TEXSZ_W+1:0] sx;
    sx = {2'b00, s};
    if (s == '0) begin
      return rccsg_pkg::TEXSZ_W'(1);
    end else if (sx > (rccsg_pkg::TEXSZ_W + 2)'(MAX_TEXTURE_SIZE)) begin
      return rccsg_pkg::TEXSZ_W'(MAX_TEXTURE_SIZE);
    end
    return s;
  endfunction

  // Configuration registers.
  logic [rccsg_pkg::COLOR_W-1:0] ceil_color_q, floor_color_q;
  logic [rccsg_pkg::TEXSZ_W-1:0] tex_width_q, tex_height_q;
  logic                          cfg_wr;

  assign cfg_wr = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ceil_color_q  <= '0;
      floor_color_q <= '0;
      tex_width_q   <= rccsg_pkg::TEXSZ_W'(64);
      tex_height_q  <= rccsg_pkg::TEXSZ_W'(64);
    end else if (cfg_wr) begin
      case (paddr_i[3:2])
        rccsg_pkg::REG_CEIL_COLOR:  ceil_color_q  <= pwdata_i;
        rccsg_pkg::REG_FLOOR_COLOR: floor_color_q <= pwdata_i;
        rccsg_pkg::REG_TEX_WIDTH:   tex_width_q   <= pwdata_i[rccsg_pkg::TEXSZ_W-1:0];
        rccsg_pkg::REG_TEX_HEIGHT:  tex_height_q  <= pwdata_i[rccsg_pkg::TEXSZ_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr_i[3:2])
      rccsg_pkg::REG_CEIL_COLOR:  prdata_o = ceil_color_q;
      rccsg_pkg::REG_FLOOR_COLOR: prdata_o = floor_color_q;
      rccsg_pkg::REG_TEX_WIDTH:   prdata_o = rccsg_pkg::APB_DATA_W'(tex_width_q);
      rccsg_pkg::REG_TEX_HEIGHT:  prdata_o = rccsg_pkg::APB_DATA_W'(tex_height_q);
      default:                    prdata_o = '0;
    endcase
  end

  logic [rccsg_pkg::TEXSZ_W-1:0] tw_eff, th_eff;
  assign tw_eff = eff_size(tex_width_q);
  assign th_eff = eff_size(tex_height_q);

  // Latched input beat.
  logic                          mode_q;
  logic [rccsg_pkg::COL_W-1:0]   col_q;
  logic [rccsg_pkg::DIST_W-1:0]  dist_q;
  logic [rccsg_pkg::FRAC_W-1:0]  hx_q, hy_q;
  logic                          xmaj_q, mir_q;
  logic [rccsg_pkg::TEXID_W-1:0] tex_q;
  logic [rccsg_pkg::ROW_W-1:0]   row_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= s_tuser_i;
      col_q  <= s_tdata_i[9:0];
      dist_q <= s_tdata_i[25:10];
      hx_q   <= s_tdata_i[37:26];
      hy_q   <= s_tdata_i[49:38];
      xmaj_q <= s_tdata_i[50];
      mir_q  <= s_tdata_i[51];
      tex_q  <= s_tdata_i[53:52];
      row_q  <= s_tdata_i[62:54];
    end
  end

  // Column state.
  logic [rccsg_pkg::COL_W-1:0]    cur_col_q;
  logic [SPAN_W-1:0]              span_start_q, span_end_q;
  logic [rccsg_pkg::HEIGHT_W-1:0] span_height_q;
  logic [rccsg_pkg::TEXEL_W-1:0]  col_texel_x_q, tx_pend_q;
  logic [rccsg_pkg::TEXID_W-1:0]  col_tex_q;

  // Texel column of a setup beat, registered when the divider starts.
  logic [rccsg_pkg::FRAC_W-1:0]  frac;
  logic [TXP_W-1:0]              tx_prod;
  logic [rccsg_pkg::TEXSZ_W-1:0] tx_raw, tx_mir, tx_clip;

  always_comb begin
    frac    = xmaj_q ? hy_q : hx_q;
    tx_prod = TXP_W'(frac) * TXP_W'(tw_eff);
    tx_raw  = tx_prod[TXP_W-1:rccsg_pkg::FRAC_W];
    tx_mir  = tx_raw;
    if (mir_q) begin
      tx_mir = (tx_raw < tw_eff) ? (tw_eff - rccsg_pkg::TEXSZ_W'(1) - tx_raw) : '0;
    end
    tx_clip = (tx_mir >= tw_eff) ? (tw_eff - rccsg_pkg::TEXSZ_W'(1)) : tx_mir;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      tx_pend_q <= tx_clip[rccsg_pkg::TEXEL_W-1:0];
    end
  end

  // Row classification against the stored span.
  logic [CMP_W-1:0]               r_ext, st_ext, en_ext;
  logic                           is_ceil, is_wall;
  logic [rccsg_pkg::ROW_W-1:0]    row_diff;
  logic [TYP_W-1:0]               ty_prod;

  always_comb begin
    r_ext    = CMP_W'(row_q);
    st_ext   = CMP_W'(span_start_q);
    en_ext   = CMP_W'(span_end_q);
    is_ceil  = (r_ext < st_ext);
    is_wall  = !is_ceil && (r_ext <= en_ext);
    row_diff = rccsg_pkg::ROW_W'(r_ext - st_ext);
    ty_prod  = TYP_W'(row_diff) * TYP_W'(th_eff);
  end

  // Divider operands: screen height times 256 over distance, or texel row scaling.
  logic [rccsg_pkg::DIV_W-1:0] div_dvd, div_quot;
  logic [rccsg_pkg::DVS_W-1:0] div_dvs, dist_clamp;
  logic                        div_busy, div_done;

  always_comb begin
    dist_clamp = (dist_q < rccsg_pkg::MIN_DIST) ? rccsg_pkg::MIN_DIST : dist_q;
    div_dvd    = mode_q ? rccsg_pkg::DIV_W'(ty_prod) : SETUP_NUM;
    div_dvs    = mode_q ? rccsg_pkg::DVS_W'(span_height_q) : dist_clamp;
  end

  rccsg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Span of a new column from the projected height.
  logic [rccsg_pkg::HEIGHT_W-1:0] h_sat;
  logic [SUM_W-1:0]               hh, s_v, e_sum, e_v;

  always_comb begin
    h_sat = (div_quot > rccsg_pkg::DIV_W'(rccsg_pkg::HEIGHT_MAX)) ?
            rccsg_pkg::HEIGHT_MAX : div_quot[rccsg_pkg::HEIGHT_W-1:0];
    if (h_sat == '0) begin
      h_sat = rccsg_pkg::HEIGHT_W'(1);
    end
    hh    = SUM_W'(h_sat[rccsg_pkg::HEIGHT_W-1:1]);
    s_v   = (hh > HALF_V) ? '0 : (HALF_V - hh);
    e_sum = HALF_V + hh;
    e_v   = (e_sum > LAST_ROW) ? LAST_ROW : e_sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q     <= '0;
      span_start_q  <= '0;
      span_end_q    <= '0;
      span_height_q <= rccsg_pkg::HEIGHT_W'(1);
      col_texel_x_q <= '0;
      col_tex_q     <= '0;
    end else if (cmd_i.commit) begin
      cur_col_q     <= col_q;
      span_start_q  <= SPAN_W'(s_v);
      span_end_q    <= SPAN_W'(e_v);
      span_height_q <= h_sat;
      col_texel_x_q <= tx_pend_q;
      col_tex_q     <= tex_q;
    end
  end

  // Texel row of a wall pixel, clipped to the texture.
  logic [rccsg_pkg::DIV_W-1:0] ty_clip;
  assign ty_clip = (div_quot >= rccsg_pkg::DIV_W'(th_eff)) ?
                   rccsg_pkg::DIV_W'(th_eff - rccsg_pkg::TEXSZ_W'(1)) : div_quot;

  // Output register; it frees up in the same cycle its beat is taken.
  logic                          m_valid_q;
  logic [rccsg_pkg::KIND_W-1:0]  kind_q;
  logic [rccsg_pkg::COL_W-1:0]   o_col_q;
  logic [rccsg_pkg::ROW_W-1:0]   o_row_q;
  logic [rccsg_pkg::COLOR_W-1:0] o_color_q;
  logic [rccsg_pkg::TEXID_W-1:0] o_tex_q;
  logic [rccsg_pkg::TEXEL_W-1:0] o_tcol_q, o_trow_q;
  logic                          out_free;

  assign out_free = !m_valid_q || m_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      o_col_q   <= cur_col_q;
      o_row_q   <= row_q;
      o_color_q <= '0;
      o_tex_q   <= '0;
      o_tcol_q  <= '0;
      o_trow_q  <= '0;
      if (is_ceil) begin
        kind_q    <= rccsg_pkg::KIND_CEIL;
        o_color_q <= ceil_color_q;
      end else if (is_wall) begin
        kind_q   <= rccsg_pkg::KIND_WALL;
        o_tex_q  <= col_tex_q;
        o_tcol_q <= col_texel_x_q;
        o_trow_q <= ty_clip[rccsg_pkg::TEXEL_W-1:0];
      end else begin
        kind_q    <= rccsg_pkg::KIND_FLOOR;
        o_color_q <= floor_color_q;
      end
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tuser_o  = kind_q;
  assign m_tdata_o  = {3'b000, o_trow_q, o_tcol_q, o_tex_q, o_color_q, o_row_q, o_col_q};

  always_comb begin
    sts_o          = '0;
    sts_o.mode     = mode_q;
    sts_o.is_wall  = is_wall;
    sts_o.div_done = div_done;
    sts_o.out_free = out_free;
  end

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> !div_busy)
    else $error("divider started while still busy");

  a_height_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    span_height_q != '0)
    else $error("stored span height is zero");

  a_span_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> span_start_q <= span_end_q)
    else $error("span start lies past span end");

  a_texel_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && kind_q == rccsg_pkg::KIND_WALL) |->
      rccsg_pkg::TEXSZ_W'(o_trow_q) <= th_eff - rccsg_pkg::TEXSZ_W'(1))
    else $error("texel row beyond texture height");

endmodule

FILE: sv/raycast_column_span_generator_top.sv
// Top level of the raycast column span generator.
//
// Input stream (s_axis_*): one beat per item. tuser is the mode: 0 sets up
// a column (distance, hit fractions, axis and mirror flags, texture id),
// 1 requests one screen row of the current column. Output stream (m_axis_*):
// one pixel descriptor per row request, none for a setup; tuser is the pixel
// kind (ceiling, wall texel, floor).
// The APB port holds the ceiling and floor colors and the texture size.
// Write it only while no beat is in flight.
// Sequence: a setup passes through decode and the divide state and then commits
// the column span; a wall row passes through decode, the divide state and the
// emit step; a ceiling or floor row through decode and the emit step only.
// One item is worked on at a time; the output register lets the next item be
// accepted while a finished descriptor waits. If the receiver stalls, only a
// second descriptor waits in the emit step until the first one is taken.
// After reset the colors are zero, textures are 64 by 64 and the column span
// covers row 0 only, so row 0 is wall and every other row is floor.
module raycast_column_span_generator_top #(
  parameter int unsigned SCREEN_ROWS      = rccsg_pkg::SCREEN_ROWS_DEF,
  parameter int unsigned MAX_TEXTURE_SIZE = rccsg_pkg::MAX_TEXTURE_SIZE_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // column_x[9:0], distance[25:10], hit_x_frac[37:26], hit_y_frac[49:38],
  // x_major[50], mirror[51], texture_id[53:52], row[62:54], zero[63]
  input  logic [rccsg_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // mode[0]
  input  logic                                  s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // out_column[9:0], out_row[18:10], solid_color[50:19], out_texture[52:51],
  // texel_column[60:53], texel_row[68:61], zero[71:69]
  output logic [rccsg_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // pixel_kind[1:0]
  output logic [rccsg_pkg::KIND_W-1:0]          m_axis_tuser,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [rccsg_pkg::ADDR_W-1:0]          paddr,
  input  logic [rccsg_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [rccsg_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                  pready
);

  rccsg_pkg::cmd_t cmd;
  rccsg_pkg::sts_t sts;

  assign pready = 1'b1;

  rccsg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rccsg_dp #(
    .SCREEN_ROWS      (SCREEN_ROWS),
    .MAX_TEXTURE_SIZE (MAX_TEXTURE_SIZE)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser),
    .psel_i     (psel),
    .penable_i  (penable),
    .pwrite_i   (pwrite),
    .paddr_i    (paddr),
    .pwdata_i   (pwdata),
    .prdata_o   (prdata)
  );

endmodule
